### design/sqpf_pkg.sv
`timescale 1ns / 1ps

package sqpf_pkg;

    // Front-end scaling of the ADC code
    localparam int SCALE_DIVISOR = 600;
    localparam int SAMPLE_BITS   = 12;
    localparam int SAMPLE_W      = SAMPLE_BITS;
    localparam int X_W           = SAMPLE_BITS + 1;

    // Division by SCALE_DIVISOR as multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = 26;
    localparam logic signed [31:0] RECIP_C =
        32'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR));

    // Datapath widths
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 66;
    localparam int SHIFT_W = 5;

    // Rounding points of the filter (Q4.28 coefficients) and the rotation (Q1.15)
    localparam int FILT_FRAC = 28;
    localparam int PARK_FRAC = 15;
    localparam logic signed [ACC_W-1:0] FILT_HALF = ACC_W'(1) <<< (FILT_FRAC - 1);
    localparam logic signed [ACC_W-1:0] PARK_HALF = ACC_W'(1) <<< (PARK_FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX   = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN   = -ACC_W'(64'sd2147483648);

    // Register map, word index on paddr[4:2]
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_SAMPLE_OFFSET = 3'd0;
    localparam logic [2:0] REG_BANDPASS_GAIN = 3'd1;
    localparam logic [2:0] REG_LOWPASS_GAIN  = 3'd2;
    localparam logic [2:0] REG_FEEDBACK_ONE  = 3'd3;
    localparam logic [2:0] REG_FEEDBACK_TWO  = 3'd4;

    localparam logic [SAMPLE_W-1:0]      RST_SAMPLE_OFFSET = SAMPLE_W'(2457);
    localparam logic signed [DATA_W-1:0] RST_BANDPASS_GAIN = 32'sd2091730;
    localparam logic signed [DATA_W-1:0] RST_LOWPASS_GAIN  = 32'sd16428;
    localparam logic signed [DATA_W-1:0] RST_FEEDBACK_ONE  = -32'sd532621579;
    localparam logic signed [DATA_W-1:0] RST_FEEDBACK_TWO  = 32'sd264252158;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCALE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_LOAD
    } state_t;

    // One product per code, in issue order
    typedef enum logic [3:0] {
        OP_A_GX,
        OP_A_GX2,
        OP_A_A1,
        OP_A_A2,
        OP_B_HX,
        OP_B_HX1,
        OP_B_HX2,
        OP_B_A1,
        OP_B_A2,
        OP_D_CA,
        OP_D_SB,
        OP_Q_SA,
        OP_Q_CB
    } op_t;

    typedef struct packed {
        logic               neg;
        logic [SHIFT_W-1:0] shift;
    } term_ctl_t;

endpackage

### design/sogi_quadrature_park_front.sv
`timescale 1ns / 1ps

// SOGI quadrature generator with Park rotation. Each request carries one raw
// 12-bit ADC code of the grid voltage plus the sine and cosine (Q1.15) of the
// tracked angle. The code has sample_offset removed and is divided by 600
// (truncated toward zero); the result drives a bilinear band-pass (alpha) and
// a low-pass (beta) biquad sharing the denominator (1, feedback_one,
// feedback_two), all coefficients Q4.28 over APB. alpha and beta are rotated
// into d and q. All four results are Q16.16, rounded half up and saturated to
// 32 bits; the filter histories keep the saturated values. Every product goes
// through one shared 32x32 multiplier with one registered product stage, run
// by a small sequencer: one reciprocal product for the scaling, nine filter
// products and four rotation products. s_tready stays low from acceptance
// until the sequencer is back in idle. The finished result sits in an output
// register, so the next request is taken while it waits; the block only
// stalls at its final load step if the previous result has still not been
// taken.
module sogi_quadrature_park_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    // raw_sample [11:0], angle_sine [27:12], angle_cosine [43:28], zero [47:44]
    input  logic [47:0]                  s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // alpha_out [31:0], beta_out [63:32], direct_out [95:64], quadrature_out [127:96]
    output logic [127:0]                 m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sqpf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int SW = sqpf_pkg::SAMPLE_W;
    localparam int XW = sqpf_pkg::X_W;
    localparam int DW = sqpf_pkg::DATA_W;
    localparam int AW = sqpf_pkg::ACC_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0]        offset_reg;
    logic signed [DW-1:0] bp_gain_reg;
    logic signed [DW-1:0] lp_gain_reg;
    logic signed [DW-1:0] fb_one_reg;
    logic signed [DW-1:0] fb_two_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= sqpf_pkg::RST_SAMPLE_OFFSET;
            bp_gain_reg <= sqpf_pkg::RST_BANDPASS_GAIN;
            lp_gain_reg <= sqpf_pkg::RST_LOWPASS_GAIN;
            fb_one_reg  <= sqpf_pkg::RST_FEEDBACK_ONE;
            fb_two_reg  <= sqpf_pkg::RST_FEEDBACK_TWO;
        end else if (cfg_wr) begin
            // Writes beyond the register list are dropped
            unique case (paddr[4:2])
                sqpf_pkg::REG_SAMPLE_OFFSET: offset_reg  <= pwdata[SW-1:0];
                sqpf_pkg::REG_BANDPASS_GAIN: bp_gain_reg <= pwdata;
                sqpf_pkg::REG_LOWPASS_GAIN:  lp_gain_reg <= pwdata;
                sqpf_pkg::REG_FEEDBACK_ONE:  fb_one_reg  <= pwdata;
                sqpf_pkg::REG_FEEDBACK_TWO:  fb_two_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            sqpf_pkg::REG_SAMPLE_OFFSET: prdata = 32'(offset_reg);
            sqpf_pkg::REG_BANDPASS_GAIN: prdata = bp_gain_reg;
            sqpf_pkg::REG_LOWPASS_GAIN:  prdata = lp_gain_reg;
            sqpf_pkg::REG_FEEDBACK_ONE:  prdata = fb_one_reg;
            sqpf_pkg::REG_FEEDBACK_TWO:  prdata = fb_two_reg;
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    sqpf_pkg::state_t state_reg, state_next;
    sqpf_pkg::op_t    op_reg, op_next;

    logic [SW-1:0]        raw_reg;
    logic signed [15:0]   sin_reg;
    logic signed [15:0]   cos_reg;
    logic                 x_neg_reg, x_neg_next;
    logic signed [XW-1:0] x_reg, x_next;

    // Filter histories: x1/x2 inputs, ya1/ya2 and yb1/yb2 outputs
    logic signed [XW-1:0] x1_reg, x1_next, x2_reg, x2_next;
    logic signed [DW-1:0] ya1_reg, ya1_next, ya2_reg, ya2_next;
    logic signed [DW-1:0] yb1_reg, yb1_next, yb2_reg, yb2_next;
    logic signed [DW-1:0] d_reg, d_next, q_reg, q_next;

    logic signed [sqpf_pkg::PROD_W-1:0] prod_reg;
    sqpf_pkg::term_ctl_t                prod_ctl_reg, prod_ctl_next;
    logic                               prod_vld_reg, prod_vld_next;
    logic signed [AW-1:0]               acc_reg, acc_next;

    logic         m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next;

    // Shared multiplier
    logic signed [DW-1:0]               mul_a, mul_b;
    logic signed [sqpf_pkg::PROD_W-1:0] mul_p;

    // Misc combinational
    logic signed [SW:0]   diff;
    logic [SW-1:0]        mag;
    logic [SW-1:0]        quo;
    logic                 grp_last;
    logic                 is_park;
    logic                 out_free;
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] rnd_sum;
    logic signed [AW-1:0] rnd_shr;
    logic signed [DW-1:0] rnd_val;

    assign s_tready = (state_reg == sqpf_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Centered sample and its magnitude; |diff| never exceeds the code range
    assign diff = $signed({1'b0, raw_reg}) - $signed({1'b0, offset_reg});
    assign mag  = diff[SW] ? SW'(-diff) : diff[SW-1:0];
    assign quo  = prod_reg[sqpf_pkg::RECIP_SHIFT +: SW];

    assign grp_last = (op_reg == sqpf_pkg::OP_A_A2) || (op_reg == sqpf_pkg::OP_B_A2) ||
                      (op_reg == sqpf_pkg::OP_D_SB) || (op_reg == sqpf_pkg::OP_Q_CB);
    assign is_park  = (op_reg == sqpf_pkg::OP_D_SB) || (op_reg == sqpf_pkg::OP_Q_CB);

    assign mul_p = mul_a * mul_b;

    // Scale the registered product to Q.44 (filter) or Q.31 (rotation) weight
    assign term = (AW'(prod_reg) <<< prod_ctl_reg.shift);

    // Round half up at the group's binary point, then saturate to 32 bits
    assign rnd_sum = acc_reg + (is_park ? sqpf_pkg::PARK_HALF : sqpf_pkg::FILT_HALF);
    assign rnd_shr = is_park ? (rnd_sum >>> sqpf_pkg::PARK_FRAC)
                             : (rnd_sum >>> sqpf_pkg::FILT_FRAC);
    always_comb begin
        if (rnd_shr > sqpf_pkg::SAT_MAX) begin
            rnd_val = {1'b0, {(DW-1){1'b1}}};
        end else if (rnd_shr < sqpf_pkg::SAT_MIN) begin
            rnd_val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            rnd_val = rnd_shr[DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            sqpf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sqpf_pkg::ST_DIV;
                    op_next    = sqpf_pkg::OP_A_GX;
                end
            end
            sqpf_pkg::ST_DIV:   state_next = sqpf_pkg::ST_SCALE;
            sqpf_pkg::ST_SCALE: state_next = sqpf_pkg::ST_MAC;
            sqpf_pkg::ST_MAC: begin
                // Issue one product per cycle until the group's last one
                if (grp_last) begin
                    state_next = sqpf_pkg::ST_DRAIN;
                end else begin
                    op_next = sqpf_pkg::op_t'(op_reg + 4'd1);
                end
            end
            sqpf_pkg::ST_DRAIN: state_next = sqpf_pkg::ST_ROUND;
            sqpf_pkg::ST_ROUND: begin
                if (op_reg == sqpf_pkg::OP_Q_CB) begin
                    state_next = sqpf_pkg::ST_LOAD;
                end else begin
                    state_next = sqpf_pkg::ST_MAC;
                    op_next    = sqpf_pkg::op_t'(op_reg + 4'd1);
                end
            end
            sqpf_pkg::ST_LOAD: begin
                // Hold until the output register is free
                if (out_free) begin
                    state_next = sqpf_pkg::ST_IDLE;
                end
            end
            default: state_next = sqpf_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control: operand selection and register updates
    // ------------------------------------------------------------------
    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        prod_ctl_next = '0;
        prod_vld_next = 1'b0;
        x_neg_next    = x_neg_reg;
        x_next        = x_reg;
        x1_next       = x1_reg;
        x2_next       = x2_reg;
        ya1_next      = ya1_reg;
        ya2_next      = ya2_reg;
        yb1_next      = yb1_reg;
        yb2_next      = yb2_reg;
        d_next        = d_reg;
        q_next        = q_reg;
        acc_next      = acc_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        // Accumulate the product issued in the previous cycle
        if (prod_vld_reg) begin
            acc_next = prod_ctl_reg.neg ? (acc_reg - term) : (acc_reg + term);
        end

        unique case (state_reg)
            sqpf_pkg::ST_DIV: begin
                // |diff| * ceil(2^26 / divisor)
                mul_a      = DW'(mag);
                mul_b      = sqpf_pkg::RECIP_C;
                x_neg_next = diff[SW];
            end
            sqpf_pkg::ST_SCALE: begin
                // Truncate toward zero: apply the sign after the magnitude quotient
                x_next = x_neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
            end
            sqpf_pkg::ST_MAC: begin
                prod_vld_next = 1'b1;
                case (op_reg)
                    sqpf_pkg::OP_A_GX: begin
                        mul_a = bp_gain_reg; mul_b = DW'(x_reg);
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd16};
                    end
                    sqpf_pkg::OP_A_GX2: begin
                        mul_a = bp_gain_reg; mul_b = DW'(x2_reg);
                        prod_ctl_next = '{neg: 1'b1, shift: 5'd16};
                    end
                    sqpf_pkg::OP_A_A1: begin
                        mul_a = fb_one_reg; mul_b = ya1_reg;
                        prod_ctl_next = '{neg: 1'b1, shift: 5'd0};
                    end
                    sqpf_pkg::OP_A_A2: begin
                        mul_a = fb_two_reg; mul_b = ya2_reg;
                        prod_ctl_next = '{neg: 1'b1, shift: 5'd0};
                    end
                    sqpf_pkg::OP_B_HX: begin
                        mul_a = lp_gain_reg; mul_b = DW'(x_reg);
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd16};
                    end
                    sqpf_pkg::OP_B_HX1: begin
                        // 2h * x1: one more bit of shift
                        mul_a = lp_gain_reg; mul_b = DW'(x1_reg);
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd17};
                    end
                    sqpf_pkg::OP_B_HX2: begin
                        mul_a = lp_gain_reg; mul_b = DW'(x2_reg);
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd16};
                    end
                    sqpf_pkg::OP_B_A1: begin
                        mul_a = fb_one_reg; mul_b = yb1_reg;
                        prod_ctl_next = '{neg: 1'b1, shift: 5'd0};
                    end
                    sqpf_pkg::OP_B_A2: begin
                        mul_a = fb_two_reg; mul_b = yb2_reg;
                        prod_ctl_next = '{neg: 1'b1, shift: 5'd0};
                    end
                    sqpf_pkg::OP_D_CA: begin
                        mul_a = DW'(cos_reg); mul_b = ya1_reg;
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd0};
                    end
                    sqpf_pkg::OP_D_SB: begin
                        mul_a = DW'(sin_reg); mul_b = yb1_reg;
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd0};
                    end
                    sqpf_pkg::OP_Q_SA: begin
                        mul_a = DW'(sin_reg); mul_b = ya1_reg;
                        prod_ctl_next = '{neg: 1'b1, shift: 5'd0};
                    end
                    sqpf_pkg::OP_Q_CB: begin
                        mul_a = DW'(cos_reg); mul_b = yb1_reg;
                        prod_ctl_next = '{neg: 1'b0, shift: 5'd0};
                    end
                    default: prod_vld_next = 1'b0;
                endcase
            end
            sqpf_pkg::ST_ROUND: begin
                acc_next = '0;
                case (op_reg)
                    sqpf_pkg::OP_A_A2: begin
                        ya2_next = ya1_reg;
                        ya1_next = rnd_val;
                    end
                    sqpf_pkg::OP_B_A2: begin
                        // Beta is the last user of the input history
                        yb2_next = yb1_reg;
                        yb1_next = rnd_val;
                        x2_next  = x1_reg;
                        x1_next  = x_reg;
                    end
                    sqpf_pkg::OP_D_SB: d_next = rnd_val;
                    sqpf_pkg::OP_Q_CB: q_next = rnd_val;
                    default: ;
                endcase
            end
            sqpf_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_data_next  = {q_reg, d_reg, yb1_reg, ya1_reg};
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sqpf_pkg::ST_IDLE;
            op_reg       <= sqpf_pkg::OP_A_GX;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            ya1_reg      <= '0;
            ya2_reg      <= '0;
            yb1_reg      <= '0;
            yb2_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            prod_vld_reg <= prod_vld_next;
            acc_reg      <= acc_next;
            m_valid_reg  <= m_valid_next;
            x1_reg       <= x1_next;
            x2_reg       <= x2_next;
            ya1_reg      <= ya1_next;
            ya2_reg      <= ya2_next;
            yb1_reg      <= yb1_next;
            yb2_reg      <= yb2_next;
        end
    end

    always_ff @(posedge aclk) begin
        // Capture the request payload
        if (s_tvalid && s_tready) begin
            raw_reg <= s_tdata[11:0];
            sin_reg <= s_tdata[27:12];
            cos_reg <= s_tdata[43:28];
        end
        prod_reg     <= mul_p;
        prod_ctl_reg <= prod_ctl_next;
        x_neg_reg    <= x_neg_next;
        x_reg        <= x_next;
        d_reg        <= d_next;
        q_reg        <= q_next;
        m_data_reg   <= m_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while sequencer busy");

    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sqpf_pkg::ST_SCALE) |-> (acc_reg == '0))
        else $error("accumulator not clear at start of request");

    a_prod_from_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> $past(state_reg == sqpf_pkg::ST_MAC))
        else $error("product accumulated without an issue step");

    a_load_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sqpf_pkg::ST_LOAD && m_valid_reg && !m_tready)
        |=> (state_reg == sqpf_pkg::ST_LOAD && m_valid_reg))
        else $error("result overwritten before it was taken");

endmodule
